// File: rtl/alpt_pkg.sv
// ============================================================================
// Address pool lease table: shared package
// Sizes, opcode and status codes, transaction payloads and the control
// bundle of the shared add/subtract unit.
// ============================================================================
package alpt_pkg;

    // Table size and the widths that follow from it.
    localparam int POOL_ENTRIES = 64;
    localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CTR_W        = $clog2(POOL_ENTRIES + 1);

    // Fixed field widths.
    localparam int ADDR_W  = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = 6;
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    // Register map: the index is taken from paddr bit 2.
    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_LEASE = 1'b1;

    localparam logic [TIME_W-1:0] LEASE_RESET = TIME_W'(86400);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_SWEEP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode             opcode;
        logic [MAC_W-1:0]    hw_mac;
        logic [ADDR_W-1:0]   request_address;
        logic [TIME_W-1:0]   current_time;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   result_address;
        logic [ENTRY_W-1:0]  entry_number;
        logic [CNT_W-1:0]    freed_count;
    } t_rsp;

    // One lease record as kept in the lease memory.
    typedef struct packed {
        logic [MAC_W-1:0]    mac;
        logic [TIME_W-1:0]   expiry;
    } t_lease;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [ADDR_W-1:0]   a;
        logic [ADDR_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic                carry;
        logic [ADDR_W-1:0]   sum;
    } t_alu_rsp;

endpackage

// File: rtl/alpt_alu.sv
// ============================================================================
// Address pool lease table: shared add/subtract unit
// One 32-bit adder with carry out, used for expiry, address, release offset
// and expiry compare computations in turn.
// ============================================================================
module alpt_alu import alpt_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic              w_cin;
    logic [ADDR_W-1:0] w_b;

    // Subtraction is a plus the inverted b plus one; carry out set means no borrow.
    always_comb begin
        w_cin = (i_req.op == ALU_SUB);
        w_b   = w_cin ? ~i_req.b : i_req.b;
        {o_rsp.carry, o_rsp.sum} = {1'b0, i_req.a} + {1'b0, w_b}
                                 + {{ADDR_W{1'b0}}, w_cin};
    end

endmodule

// File: rtl/alpt_store.sv
// ============================================================================
// Address pool lease table: lease memory
// Holds the MAC and expiry of every entry. One write port and one read
// port with registered read data.
// ============================================================================
module alpt_store import alpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_lease           i_wr_data,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_lease           o_rd_data
);

    t_lease r_mem [POOL_ENTRIES];
    t_lease r_rd_data;

    // Contents are only read for entries marked in use, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/address_pool_lease_table_unit.sv
// ============================================================================
// Address pool lease table
// Lease table over a pool of consecutive addresses with allocate, release,
// lookup-by-MAC and expiry-sweep requests and an APB-style register port.
//
// One request is handled at a time; the input is stalled until its result
// has been moved into the output register, which lets the next request
// start while that result still waits. The cost is set by a scan that
// visits one table entry per cycle. An allocate scans up to the first free
// entry, or the whole table when the pool is full; a release needs no scan,
// since its entry follows from one subtraction; a lookup scans up to the
// entry that it hits, or the whole table on a miss; a sweep always scans
// the whole table, bounded by the single read port of the lease memory.
// The in-use marks clear at reset; the lease memory needs no clearing
// pass, so the block is ready right after reset.
// ============================================================================
module address_pool_lease_table_unit import alpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_req               i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_rsp               o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_EXP,
        S_ALLOC_ADDR,
        S_RELEASE,
        S_SCAN,
        S_FOUND_ADDR,
        S_DONE
    } t_state;

    // Configuration registers.
    logic [ADDR_W-1:0] r_base;
    logic [TIME_W-1:0] r_lease;

    // Sequencer state and per-transaction registers.
    t_state              r_state,    n_state;
    t_opcode             r_op,       n_op;
    logic [MAC_W-1:0]    r_mac,      n_mac;
    logic [ADDR_W-1:0]   r_req,      n_req;
    logic [TIME_W-1:0]   r_now,      n_now;
    logic [CTR_W-1:0]    r_idx,      n_idx;
    logic                r_rd_vld,   n_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx,   n_rd_idx;
    logic [POOL_ENTRIES-1:0] r_in_use, n_in_use;
    logic [CNT_W-1:0]    r_count,    n_count;
    t_status             r_status,   n_status;
    logic [ADDR_W-1:0]   r_addr,     n_addr;
    logic [ENTRY_W-1:0]  r_entry,    n_entry;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out_data,  n_out_data;

    t_alu_req w_alu_req;
    t_alu_rsp w_alu_rsp;
    logic     w_wr_en;
    t_lease   w_wr_data;
    t_lease   w_rd_data;
    logic     w_idx_end;
    logic     w_cfg_wr;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    // The register is selected by address bit 2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_lease <= LEASE_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_BASE:  r_base  <= pwdata;
                REG_LEASE: r_lease <= pwdata;
                default:   r_base  <= r_base;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_LEASE) ? r_lease : r_base;

    // ------------------------------------------------------------------
    // Shared arithmetic unit and lease memory
    // ------------------------------------------------------------------
    alpt_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    alpt_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (r_idx[IDX_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_idx  (r_idx[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_idx_end = (r_idx == CTR_W'(POOL_ENTRIES));

    // ------------------------------------------------------------------
    // Sequencer next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_mac       = r_mac;
        n_req       = r_req;
        n_now       = r_now;
        n_idx       = r_idx;
        n_rd_vld    = r_rd_vld;
        n_rd_idx    = r_rd_idx;
        n_in_use    = r_in_use;
        n_count     = r_count;
        n_status    = r_status;
        n_addr      = r_addr;
        n_entry     = r_entry;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // By default the unit forms the address of the current entry.
        w_alu_req.op = ALU_ADD;
        w_alu_req.a  = r_base;
        w_alu_req.b  = ADDR_W'(r_idx);

        w_wr_en          = 1'b0;
        w_wr_data.mac    = r_mac;
        w_wr_data.expiry = w_alu_rsp.carry ? '1 : w_alu_rsp.sum;

        // The output register empties when its transaction is taken.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.opcode;
                    n_mac    = i_in_data.hw_mac;
                    n_req    = i_in_data.request_address;
                    n_now    = i_in_data.current_time;
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_count  = '0;
                    n_status = ST_OK;
                    n_addr   = '0;
                    n_entry  = '0;
                    case (i_in_data.opcode)
                        OP_ALLOC:   n_state = S_ALLOC_SCAN;
                        OP_RELEASE: n_state = S_RELEASE;
                        OP_LOOKUP:  n_state = S_SCAN;
                        OP_SWEEP:   n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end

            // Walk the in-use marks for the first free entry.
            S_ALLOC_SCAN: begin
                if (w_idx_end) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else if (!r_in_use[r_idx[IDX_W-1:0]]) begin
                    n_state = S_ALLOC_EXP;
                end else begin
                    n_idx = r_idx + CTR_W'(1);
                end
            end

            // Saturating expiry, then record the lease.
            S_ALLOC_EXP: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = r_now;
                w_alu_req.b  = r_lease;
                w_wr_en      = 1'b1;
                n_in_use[r_idx[IDX_W-1:0]] = 1'b1;
                n_state      = S_ALLOC_ADDR;
            end

            S_ALLOC_ADDR, S_FOUND_ADDR: begin
                n_addr   = w_alu_rsp.sum;
                n_entry  = ENTRY_W'(r_idx);
                n_status = ST_OK;
                n_state  = S_DONE;
            end

            // The offset of the address from the base names the entry directly.
            S_RELEASE: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = r_req;
                w_alu_req.b  = r_base;
                if (w_alu_rsp.sum < ADDR_W'(POOL_ENTRIES)) begin
                    n_in_use[w_alu_rsp.sum[IDX_W-1:0]] = 1'b0;
                    n_addr   = r_req;
                    n_entry  = ENTRY_W'(w_alu_rsp.sum[IDX_W-1:0]);
                    n_status = ST_OK;
                end else begin
                    n_status = ST_NONE;
                end
                n_state = S_DONE;
            end

            // Pipelined scan: a read is issued each cycle and checked in the
            // cycle after. Expiry minus now borrows when the lease is over.
            S_SCAN: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = w_rd_data.expiry;
                w_alu_req.b  = r_now;
                n_rd_vld     = !w_idx_end;
                n_rd_idx     = r_idx[IDX_W-1:0];
                if (!w_idx_end) begin
                    n_idx = r_idx + CTR_W'(1);
                end
                if (r_rd_vld && r_in_use[r_rd_idx]) begin
                    if (r_op == OP_LOOKUP) begin
                        if (w_rd_data.mac == r_mac) begin
                            n_idx   = CTR_W'(r_rd_idx);
                            n_state = S_FOUND_ADDR;
                        end
                    end else if (!w_alu_rsp.carry) begin
                        n_in_use[r_rd_idx] = 1'b0;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                if (!r_rd_vld && w_idx_end) begin
                    n_status = (r_op == OP_LOOKUP) ? ST_NONE : ST_OK;
                    n_state  = S_DONE;
                end
            end

            // Hand the result to the output register once it has room.
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_data.status          = r_status;
                    n_out_data.result_address  = r_addr;
                    n_out_data.entry_number    = r_entry;
                    n_out_data.freed_count     = r_count;
                    n_state                    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_in_use    <= n_in_use;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
            r_op        <= n_op;
            r_mac       <= n_mac;
            r_req       <= n_req;
            r_now       <= n_now;
            r_idx       <= n_idx;
            r_rd_idx    <= n_rd_idx;
            r_count     <= n_count;
            r_status    <= n_status;
            r_addr      <= n_addr;
            r_entry     <= n_entry;
            r_out_data  <= n_out_data;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted transaction keeps the input stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // A failed request reports no address and no entry.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (o_out_data.result_address == '0 && o_out_data.entry_number == '0))
        else $error("failed request carries an address or entry");

    // The entry chosen by an allocate is marked in use afterwards.
    a_alloc_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC_EXP) |=> r_in_use[$past(r_idx[IDX_W-1:0])])
        else $error("allocated entry not marked in use");

    // A sweep never frees more leases than the pool holds.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POOL_ENTRIES))
        else $error("sweep count exceeds pool size");

endmodule

// File: verif/address_pool_lease_table_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Address pool lease table: self-checking testbench
// Drives allocate, release, lookup and sweep requests through the valid/stall
// request channel, writes the pool base and lease time over the APB-style
// port, and checks every response against an in-bench lease table predictor.
// ============================================================================
module address_pool_lease_table_unit_tb;
    import alpt_pkg::*;

    localparam int LONG_HOLD  = 400;
    localparam int MAX_REPORT = 10;

    // Clock, reset and DUT-facing signals; the DUT inputs are known from time zero.
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_req               in_data   = '0;
    logic               in_stall;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_rsp               out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Predicted lease table and register copies.
    logic               lease_busy   [POOL_ENTRIES];
    logic [MAC_W-1:0]   lease_mac    [POOL_ENTRIES];
    logic [TIME_W-1:0]  lease_expiry [POOL_ENTRIES];
    logic [ADDR_W-1:0]  pool_base;
    logic [TIME_W-1:0]  lease_len;

    // Requests waiting to be sent and responses still owed by the DUT.
    t_req               pending_reqs [$];
    t_rsp               lease_expect [$];

    // Stimulus helpers.
    logic [MAC_W-1:0]   known_macs [16];
    logic [TIME_W-1:0]  wall_time;
    logic               steady        = 1'b0;
    int                 hold_requests = 0;

    // Bookkeeping.
    int                 error_count     = 0;
    int                 sent_count      = 0;
    int                 checked_count   = 0;
    int                 op_count [4]    = '{0, 0, 0, 0};
    int                 full_count      = 0;
    int                 miss_count      = 0;
    int                 reclaimed_total = 0;

    address_pool_lease_table_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    // Idle lengths: mostly none or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 20);
        else return $urandom_range(30, 150);
    endfunction

    // Applies one request to the predicted table and returns its response.
    function automatic t_rsp lease_table_apply(t_req req);
        t_rsp              rsp;
        logic              hit;
        logic [TIME_W:0]   sum;
        logic [ADDR_W-1:0] slot;
        int                cnt;
        rsp = '0;
        hit = 1'b0;
        cnt = 0;
        op_count[req.opcode]++;
        case (req.opcode)
            OP_ALLOC: begin
                // The first free entry takes the lease; the expiry saturates.
                for (int i = 0; i < POOL_ENTRIES; i++) begin
                    if (!hit && !lease_busy[i]) begin
                        hit = 1'b1;
                        sum = {1'b0, req.current_time} + {1'b0, lease_len};
                        lease_busy[i]   = 1'b1;
                        lease_mac[i]    = req.hw_mac;
                        lease_expiry[i] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                        rsp.result_address = pool_base + ADDR_W'(i);
                        rsp.entry_number   = ENTRY_W'(i);
                    end
                end
                if (!hit) begin
                    rsp.status = ST_FULL;
                    full_count++;
                end
            end
            OP_RELEASE: begin
                // The entry whose address matches is freed even if it was free.
                for (int i = 0; i < POOL_ENTRIES; i++) begin
                    slot = pool_base + ADDR_W'(i);
                    if (!hit && slot == req.request_address) begin
                        hit = 1'b1;
                        lease_busy[i] = 1'b0;
                        lease_mac[i]  = '0;
                        rsp.result_address = slot;
                        rsp.entry_number   = ENTRY_W'(i);
                    end
                end
                if (!hit) begin
                    rsp.status = ST_NONE;
                    miss_count++;
                end
            end
            OP_LOOKUP: begin
                for (int i = 0; i < POOL_ENTRIES; i++) begin
                    if (!hit && lease_busy[i] && lease_mac[i] == req.hw_mac) begin
                        hit = 1'b1;
                        rsp.result_address = pool_base + ADDR_W'(i);
                        rsp.entry_number   = ENTRY_W'(i);
                    end
                end
                if (!hit) begin
                    rsp.status = ST_NONE;
                    miss_count++;
                end
            end
            default: begin
                // A lease that expires exactly now survives the sweep.
                for (int i = 0; i < POOL_ENTRIES; i++) begin
                    if (lease_busy[i] && req.current_time > lease_expiry[i]) begin
                        lease_busy[i]   = 1'b0;
                        lease_mac[i]    = '0;
                        lease_expiry[i] = '0;
                        cnt++;
                    end
                end
                rsp.freed_count = CNT_W'(cnt);
                reclaimed_total += cnt;
            end
        endcase
        return rsp;
    endfunction

    // Request driver: holds a stalled transaction, otherwise idles or sends.
    int send_gap = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                lease_expect.push_back(lease_table_apply(in_data));
                sent_count++;
            end
            if (!(in_valid && in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    send_gap = steady ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Compares one accepted response with the oldest prediction.
    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (lease_expect.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORT)
                $display("%0t: unexpected response, status %0d address %h", $realtime,
                         got.status, got.result_address);
        end else begin
            want = lease_expect.pop_front();
            checked_count++;
            if (got.status !== want.status || got.result_address !== want.result_address ||
                got.entry_number !== want.entry_number ||
                got.freed_count !== want.freed_count) begin
                error_count++;
                if (error_count <= MAX_REPORT)
                    $display("%0t: response %0d mismatch: status %0d/%0d address %h/%h %s",
                             $realtime, checked_count, want.status, got.status,
                             want.result_address, got.result_address,
                             $sformatf("entry %0d/%0d count %0d/%0d (expected/actual)",
                                       want.entry_number, got.entry_number,
                                       want.freed_count, got.freed_count));
            end
        end
    endtask

    // Response monitor with random stalls and an on-demand long hold-off.
    int hold_served = 0;
    int hold_left   = 0;
    int stall_left  = 0;
    int run_left    = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                check_result(out_data);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (run_left > 0 || steady) begin
                if (run_left > 0) run_left--;
                out_stall <= 1'b0;
            end else begin
                run_left   = $urandom_range(0, 12);
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Register write: setup cycle, then access cycle; only called when idle.
    // The register is read back once the write has landed.
    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BASE) pool_base = value;
        else lease_len = value;
        @(negedge clk);
        if (prdata !== value || pready !== 1'b1) begin
            error_count++;
            if (error_count <= MAX_REPORT)
                $display("%0t: register %0d read back %h, expected %h", $realtime,
                         idx, prdata, value);
        end
    endtask

    // Waits until every queued request has been sent and answered.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || lease_expect.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic t_req make_req(t_opcode op, logic [MAC_W-1:0] mac,
                                      logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
        t_req req;
        req.opcode          = op;
        req.hw_mac          = mac;
        req.request_address = addr;
        req.current_time    = now;
        return req;
    endfunction

    // Random request: known MACs for lookup hits, addresses near the pool,
    // and a mostly advancing clock so that sweeps find expired leases.
    function automatic t_req random_request(int alloc_w, int rel_w, int look_w, int max_step);
        t_req req;
        int   pick;
        pick = $urandom_range(0, 99);
        req.opcode = (pick < alloc_w) ? OP_ALLOC :
                     (pick < alloc_w + rel_w) ? OP_RELEASE :
                     (pick < alloc_w + rel_w + look_w) ? OP_LOOKUP : OP_SWEEP;
        req.hw_mac = ($urandom_range(0, 3) != 0) ? known_macs[$urandom_range(0, 15)]
                                                 : MAC_W'({$urandom(), $urandom()});
        pick = $urandom_range(0, 9);
        if (pick < 8) req.request_address = pool_base + ADDR_W'($urandom_range(0, 66));
        else if (pick < 9) req.request_address = pool_base - ADDR_W'($urandom_range(1, 4));
        else req.request_address = $urandom();
        wall_time = wall_time + TIME_W'($urandom_range(0, max_step));
        req.current_time = ($urandom_range(0, 9) == 0) ? $urandom() : wall_time;
        return req;
    endfunction

    task automatic queue_random(int n, int alloc_w, int rel_w, int look_w, int max_step);
        for (int k = 0; k < n; k++)
            pending_reqs.push_back(random_request(alloc_w, rel_w, look_w, max_step));
    endtask

    // Run limit.
    initial begin
        #14_000_000;
        $display("status: fail");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        logic [MAC_W-1:0] mac_a;
        logic [MAC_W-1:0] mac_b;
        logic [TIME_W-1:0] t0;

        // Predictor starts from the reset state.
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            lease_busy[i]   = 1'b0;
            lease_mac[i]    = '0;
            lease_expiry[i] = '0;
        end
        pool_base = '0;
        lease_len = LEASE_RESET;
        wall_time = '0;
        known_macs[0] = '0;
        known_macs[1] = '1;
        for (int i = 2; i < 16; i++) known_macs[i] = MAC_W'({$urandom(), $urandom()});
        mac_a = 48'h0123_4567_89AB;
        mac_b = 48'h5A5A_5A5A_5A5A;

        // Directed opening at the reset register values.
        pending_reqs.push_back(make_req(OP_ALLOC, '0, $urandom(), 32'd0));
        pending_reqs.push_back(make_req(OP_ALLOC, '1, '1, '1));
        pending_reqs.push_back(make_req(OP_ALLOC, mac_a, $urandom(), 32'd100));
        pending_reqs.push_back(make_req(OP_LOOKUP, '1, $urandom(), $urandom()));
        pending_reqs.push_back(make_req(OP_LOOKUP, mac_a, '0, '0));
        pending_reqs.push_back(make_req(OP_LOOKUP, mac_b, $urandom(), $urandom()));
        pending_reqs.push_back(make_req(OP_LOOKUP, '0, $urandom(), $urandom()));
        // Expiry boundary: entry 2 expires at 86500 and survives the first sweep.
        pending_reqs.push_back(make_req(OP_SWEEP, MAC_W'($urandom()), $urandom(), 32'd86500));
        pending_reqs.push_back(make_req(OP_SWEEP, MAC_W'($urandom()), $urandom(), 32'd86501));
        // Release of a held entry, of the now free entry, and outside the pool.
        pending_reqs.push_back(make_req(OP_RELEASE, MAC_W'($urandom()), 32'd1, $urandom()));
        pending_reqs.push_back(make_req(OP_RELEASE, '1, 32'd1, $urandom()));
        pending_reqs.push_back(make_req(OP_RELEASE, MAC_W'($urandom()), 32'd64, $urandom()));
        pending_reqs.push_back(make_req(OP_RELEASE, MAC_W'($urandom()), '1, $urandom()));
        pending_reqs.push_back(make_req(OP_LOOKUP, '1, $urandom(), $urandom()));
        pending_reqs.push_back(make_req(OP_SWEEP, '1, '1, '1));
        pending_reqs.push_back(make_req(OP_SWEEP, '0, '0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Wrapping pool with zero lease: fill it, overflow it, sweep it empty.
        write_reg(REG_BASE, 32'hFFFF_FFF0);
        write_reg(REG_LEASE, 32'd0);
        t0 = 32'h0000_1000;
        for (int i = 0; i < POOL_ENTRIES; i++)
            pending_reqs.push_back(make_req(OP_ALLOC, known_macs[i % 16], $urandom(), t0));
        pending_reqs.push_back(make_req(OP_ALLOC, mac_b, $urandom(), t0));
        pending_reqs.push_back(make_req(OP_LOOKUP, known_macs[5], $urandom(), $urandom()));
        pending_reqs.push_back(make_req(OP_SWEEP, MAC_W'($urandom()), $urandom(), t0));
        pending_reqs.push_back(make_req(OP_SWEEP, MAC_W'($urandom()), $urandom(), t0 + 1));
        for (int i = 0; i < 24; i++)
            pending_reqs.push_back(make_req(OP_ALLOC, known_macs[i % 16], $urandom(), t0 + 2));
        pending_reqs.push_back(make_req(OP_RELEASE, MAC_W'($urandom()), 32'h0000_0005,
                                        $urandom()));
        pending_reqs.push_back(make_req(OP_RELEASE, MAC_W'($urandom()), 32'hFFFF_FFF0,
                                        $urandom()));
        pending_reqs.push_back(make_req(OP_RELEASE, MAC_W'($urandom()), 32'hFFFF_FFEF,
                                        $urandom()));
        pending_reqs.push_back(make_req(OP_RELEASE, MAC_W'($urandom()), 32'h0000_002F,
                                        $urandom()));
        pending_reqs.push_back(make_req(OP_RELEASE, MAC_W'($urandom()), 32'h0000_0030,
                                        $urandom()));
        wait_drained();

        // Saturating expiry with the largest lease and top base address.
        write_reg(REG_BASE, 32'hFFFF_FFFF);
        write_reg(REG_LEASE, 32'hFFFF_FFFF);
        pending_reqs.push_back(make_req(OP_ALLOC, mac_b, $urandom(), 32'd1));
        pending_reqs.push_back(make_req(OP_SWEEP, MAC_W'($urandom()), $urandom(), '1));
        pending_reqs.push_back(make_req(OP_LOOKUP, mac_b, $urandom(), $urandom()));
        wait_drained();

        // Short leases; the receiver holds off while requests keep coming.
        write_reg(REG_BASE, $urandom());
        write_reg(REG_LEASE, 32'd20);
        queue_random(220, 40, 25, 25, 6);
        hold_requests++;
        wait_drained();

        // Same short lease with the clock near its top, so that expiries can saturate.
        wall_time = 32'hFFFF_0000;
        queue_random(200, 40, 25, 25, 1000);
        wait_drained();

        // Zero lease with no idling on either side.
        write_reg(REG_BASE, 32'd0);
        write_reg(REG_LEASE, 32'd0);
        steady = 1'b1;
        queue_random(200, 45, 20, 20, 2);
        wait_drained();
        steady = 1'b0;

        // Moderate leases; the sender pauses halfway until all is answered.
        write_reg(REG_BASE, $urandom());
        write_reg(REG_LEASE, $urandom_range(1, 500));
        queue_random(115, 40, 20, 25, 40);
        wait_drained();
        queue_random(115, 40, 20, 25, 40);
        wait_drained();

        // Typical lease time over a private pool.
        write_reg(REG_BASE, 32'hC0A8_0000);
        write_reg(REG_LEASE, 32'd86400);
        queue_random(200, 40, 25, 25, 20000);
        wait_drained();

        repeat (20) @(negedge clk);
        if (lease_expect.size() != 0) error_count += lease_expect.size();
        $display("Sent %0d requests: %0d allocate (%0d on a full pool), %0d release, %0d lookup,",
                 sent_count, op_count[OP_ALLOC], full_count, op_count[OP_RELEASE],
                 op_count[OP_LOOKUP]);
        $display("%0d sweep; %0d responses checked, %0d misses, %0d leases reclaimed, %0d errors.",
                 op_count[OP_SWEEP], checked_count, miss_count, reclaimed_total, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
